FILE: hdl/lfr_pkg.sv
// Package for the link frame receiver: byte codes, frame type codes, result types.
// Used by every module of the receiver; depends on nothing.
`default_nettype none

package lfr_pkg;

  localparam int unsigned PayloadMaxDefault = 1024;
  localparam int unsigned LenW = 11;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscFlag  = 8'h5E;
  localparam logic [7:0] EscEsc   = 8'h5D;

  // Configuration register indexes.
  localparam logic CfgAddrSender   = 1'b0;
  localparam logic CfgAddrReceiver = 1'b1;
  localparam logic [7:0] AddrSenderReset   = 8'h03;
  localparam logic [7:0] AddrReceiverReset = 8'h01;

  // Frame type codes.
  localparam logic [3:0] TypeSet   = 4'd0;
  localparam logic [3:0] TypeUa    = 4'd1;
  localparam logic [3:0] TypeRr0   = 4'd2;
  localparam logic [3:0] TypeRr1   = 4'd3;
  localparam logic [3:0] TypeRej0  = 4'd4;
  localparam logic [3:0] TypeRej1  = 4'd5;
  localparam logic [3:0] TypeDisc  = 4'd6;
  localparam logic [3:0] TypeInfo0 = 4'd7;
  localparam logic [3:0] TypeInfo1 = 4'd8;
  localparam logic [3:0] TypeError = 4'd9;

  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  typedef struct packed {
    logic            known;
    logic [3:0]      ftype;
  } ctrl_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      data;
    logic [3:0]      ftype;
    logic            ok;
    logic [LenW-1:0] len;
    logic            ovf;
  } result_t;

  // One queue entry carries every result caused by one input byte.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } qwr_t;

  function automatic ctrl_t ctrl_decode(logic [7:0] c);
    ctrl_t r;
    r.known = 1'b1;
    case (c)
      8'h03:   r.ftype = TypeSet;
      8'h07:   r.ftype = TypeUa;
      8'hAA:   r.ftype = TypeRr0;
      8'hAB:   r.ftype = TypeRr1;
      8'h54:   r.ftype = TypeRej0;
      8'h55:   r.ftype = TypeRej1;
      8'h0B:   r.ftype = TypeDisc;
      8'h00:   r.ftype = TypeInfo0;
      8'h80:   r.ftype = TypeInfo1;
      default: begin
        r.known = 1'b0;
        r.ftype = TypeError;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lfr_byte_if.sv
// Byte stream channel into the link frame receiver: valid, ready and one raw byte.
// Depends on nothing.
`default_nettype none

interface lfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/lfr_result_if.sv
// Result channel of the link frame receiver: payload bytes and frame end reports.
// Depends on lfr_pkg for the length width.
`default_nettype none

interface lfr_result_if;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic [7:0]               data_out;
  logic [3:0]               frame_type;
  logic                     check_ok;
  logic [lfr_pkg::LenW-1:0] payload_length;
  logic                     overflow;
  logic                     last_of_run;

  modport source (output valid, output result_kind, output data_out, output frame_type,
                  output check_ok, output payload_length, output overflow,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input data_out, input frame_type,
                  input check_ok, input payload_length, input overflow,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/lfr_front.sv
// Front end: header hunt, destuffing, result building; one byte a cycle unless q_full_i.
// Depends on lfr_pkg and lfr_byte_if; writes results into the queue.
`default_nettype none

module lfr_front #(
  parameter int unsigned PAYLOAD_MAX = lfr_pkg::PayloadMaxDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [7:0]        cfg_data_i,
  lfr_byte_if.sink               rx,
  input  wire logic              q_full_i,
  output lfr_pkg::qwr_t          q_wr_o
);

  localparam int unsigned CntW = $clog2(PAYLOAD_MAX + 1);

  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhFlag = 3'd1;
  localparam logic [2:0] PhAddr = 3'd2;
  localparam logic [2:0] PhCtrl = 3'd3;
  localparam logic [2:0] PhBcc  = 3'd4;
  localparam logic [2:0] PhData = 3'd5;

  typedef struct packed {
    logic            held_v;
    logic [7:0]      held;
    logic [7:0]      xr;
    logic [CntW-1:0] cnt;
    logic            ovf;
  } body_t;

  typedef struct packed {
    body_t      s;
    logic       emit;
    logic [7:0] data;
  } push_t;

  // Delivers the held byte (unless the length limit is reached) and holds the new one.
  function automatic push_t push_fn(body_t s, logic [7:0] d);
    push_t r;
    r.s    = s;
    r.emit = 1'b0;
    r.data = s.held;
    if (s.held_v) begin
      if (s.cnt < CntW'(PAYLOAD_MAX)) begin
        r.emit  = 1'b1;
        r.s.cnt = s.cnt + 1'b1;
      end else begin
        r.s.ovf = 1'b1;
      end
    end
    r.s.xr     = s.xr ^ d;
    r.s.held   = d;
    r.s.held_v = 1'b1;
    return r;
  endfunction

  logic [7:0]      addr_snd_q, addr_rcv_q;
  logic [2:0]      phase_q, phase_d;
  logic [7:0]      hdr_q, hdr_d;
  logic [3:0]      ftype_q, ftype_d;
  logic            esc_q, esc_d;
  body_t           body_q, body_d;

  logic            accept;
  logic [7:0]      b;
  lfr_pkg::ctrl_t  ctl;

  // Destuffing of the current byte as a body byte.
  logic            bp0_v, bp1_v, b_esc;
  logic [7:0]      bp0_d;

  logic            do0, do1, do_rep;
  logic [7:0]      d0;
  logic [3:0]      rep_type;
  body_t           s_start;
  push_t           pr0, pr1;
  lfr_pkg::result_t res0, res1, rep;
  logic [1:0]      nres;

  assign accept   = rx.valid & ~q_full_i;
  assign rx.ready = ~q_full_i;
  assign b        = rx.raw_byte;
  assign ctl      = lfr_pkg::ctrl_decode(b);

  always_comb begin
    bp0_v = 1'b0;
    bp0_d = b;
    bp1_v = 1'b0;
    b_esc = 1'b0;
    if (esc_q) begin
      bp0_v = 1'b1;
      if (b == lfr_pkg::EscFlag) begin
        bp0_d = lfr_pkg::FlagByte;
      end else if (b == lfr_pkg::EscEsc) begin
        bp0_d = lfr_pkg::EscByte;
      end else begin
        // An escape before any other byte passes as a literal escape byte.
        bp0_d = lfr_pkg::EscByte;
        if (b == lfr_pkg::EscByte) begin
          b_esc = 1'b1;
        end else begin
          bp1_v = 1'b1;
        end
      end
    end else if (b == lfr_pkg::EscByte) begin
      b_esc = 1'b1;
    end else begin
      bp0_v = 1'b1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    ftype_d  = ftype_q;
    esc_d    = esc_q;
    do0      = 1'b0;
    do1      = 1'b0;
    d0       = bp0_d;
    do_rep   = 1'b0;
    rep_type = ftype_q;
    s_start  = body_q;
    case (phase_q)
      PhHunt: begin
        if (b == lfr_pkg::FlagByte) begin
          phase_d = PhFlag;
        end
      end
      PhFlag: begin
        if (b == addr_snd_q || b == addr_rcv_q) begin
          hdr_d   = b;
          phase_d = PhAddr;
        end else if (b != lfr_pkg::FlagByte) begin
          phase_d = PhHunt;
        end
      end
      PhAddr: begin
        if (ctl.known) begin
          ftype_d = ctl.ftype;
          hdr_d   = hdr_q ^ b;
          phase_d = PhCtrl;
        end else begin
          phase_d = (b == lfr_pkg::FlagByte) ? PhFlag : PhHunt;
        end
      end
      PhCtrl: begin
        if (b == hdr_q) begin
          s_start = '0;
          esc_d   = 1'b0;
          phase_d = PhBcc;
        end else begin
          phase_d = (b == lfr_pkg::FlagByte) ? PhFlag : PhHunt;
        end
      end
      PhBcc: begin
        if (b == lfr_pkg::FlagByte) begin
          do_rep  = 1'b1;
          phase_d = PhHunt;
        end else begin
          do0     = bp0_v;
          do1     = bp1_v;
          esc_d   = b_esc;
          phase_d = PhData;
        end
      end
      PhData: begin
        if (b == lfr_pkg::FlagByte) begin
          do0    = esc_q;
          d0     = lfr_pkg::EscByte;
          esc_d  = 1'b0;
          do_rep = 1'b1;
          if (ftype_q != lfr_pkg::TypeInfo0 && ftype_q != lfr_pkg::TypeInfo1) begin
            rep_type = lfr_pkg::TypeError;
          end
          phase_d = PhHunt;
        end else begin
          do0   = bp0_v;
          do1   = bp1_v;
          esc_d = b_esc;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_comb begin
    pr0 = do0 ? push_fn(s_start, d0) : push_t'{s: s_start, emit: 1'b0, data: 8'h00};
    pr1 = do1 ? push_fn(pr0.s, b) : push_t'{s: pr0.s, emit: 1'b0, data: 8'h00};
    body_d = pr1.s;

    rep.kind  = lfr_pkg::KindReport;
    rep.data  = 8'h00;
    rep.ftype = rep_type;
    rep.ok    = (pr1.s.xr == 8'h00);
    rep.len   = lfr_pkg::LenW'(pr1.s.cnt);
    rep.ovf   = pr1.s.ovf;

    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    if (pr0.emit) begin
      res0.kind = lfr_pkg::KindPayload;
      res0.data = pr0.data;
      nres      = 2'd1;
    end
    if (pr1.emit) begin
      if (nres == 2'd0) begin
        res0.data = pr1.data;
      end else begin
        res1.data = pr1.data;
      end
      nres = nres + 2'd1;
    end
    if (do_rep) begin
      if (nres == 2'd0) begin
        res0 = rep;
      end else begin
        res1 = rep;
      end
      nres = nres + 2'd1;
    end
  end

  assign q_wr_o.push     = accept & (nres != 2'd0);
  assign q_wr_o.entry.two = nres[1];
  assign q_wr_o.entry.r0  = res0;
  assign q_wr_o.entry.r1  = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_snd_q <= lfr_pkg::AddrSenderReset;
      addr_rcv_q <= lfr_pkg::AddrReceiverReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lfr_pkg::CfgAddrSender) begin
        addr_snd_q <= cfg_data_i;
      end else begin
        addr_rcv_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      hdr_q   <= 8'h00;
      ftype_q <= 4'd0;
      esc_q   <= 1'b0;
      body_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      ftype_q <= ftype_d;
      esc_q   <= esc_d;
      body_q  <= body_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lfr_queue.sv
// Two-entry queue between the front end and the output stage of the receiver.
// Depends on lfr_pkg for the entry type.
`default_nettype none

module lfr_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  lfr_pkg::qwr_t  wr_i,
  output logic           full_o,
  output logic           empty_o,
  output lfr_pkg::entry_t head_o,
  input  wire logic      pop_i
);

  lfr_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_i.push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lfr_back.sv
// Output stage: hands out the one or two results of each queue entry in order.
// Depends on lfr_pkg and lfr_result_if.
`default_nettype none

module lfr_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  lfr_pkg::entry_t head_i,
  output logic            pop_o,
  lfr_result_if.source    res
);

  logic             idx_q;
  logic             last;
  logic             fire;
  lfr_pkg::result_t cur;

  assign cur   = idx_q ? head_i.r1 : head_i.r0;
  assign last  = idx_q | ~head_i.two;
  assign fire  = res.valid & res.ready;
  assign pop_o = fire & last;

  assign res.valid          = ~empty_i;
  assign res.result_kind    = cur.kind;
  assign res.data_out       = cur.data;
  assign res.frame_type     = cur.ftype;
  assign res.check_ok       = cur.ok;
  assign res.payload_length = cur.len;
  assign res.overflow       = cur.ovf;
  assign res.last_of_run    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else if (fire) begin
      idx_q <= ~last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/link_frame_receiver.sv
// Link frame receiver: takes one serial byte per cycle on rx_i whenever the two-entry
// result queue has room. A byte that causes two results (an unknown escape followed by a
// literal byte, or a closing flag right after an open escape) holds the result port for
// both, so the sustained rate is one byte a cycle while at most one result per byte is
// produced and the result port is ready; the single result port sets the rate otherwise.
// Payload bytes come out one byte late, so the check byte is never delivered; the closing
// flag brings a frame end report. Addresses are written through cfg_we_i, cfg_idx_i and
// cfg_data_i, by the user only while the block is idle; the block does not enforce it.
// Depends on lfr_pkg, lfr_byte_if, lfr_result_if, lfr_front, lfr_queue and lfr_back.
`default_nettype none

module link_frame_receiver #(
  parameter int unsigned PAYLOAD_MAX = lfr_pkg::PayloadMaxDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  lfr_byte_if.sink        rx_i,
  lfr_result_if.source    res_o
);

  lfr_pkg::qwr_t   q_wr;
  lfr_pkg::entry_t q_head;
  logic            q_full, q_empty, q_pop;

  lfr_front #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx         (rx_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr)
  );

  lfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  lfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .res     (res_o)
  );

endmodule

`default_nettype wire
